// File: rtl/rrp_pkg.sv
// ----------------------------------------------------------------------------
// rrp_pkg
// Shared constants and the status decode for the ranging result post-processor.
// ----------------------------------------------------------------------------
package rrp_pkg;

  localparam int DIV_W = 32;

  localparam logic [15:0] TARGET_RATE_RESET = 16'd2560;
  localparam logic [11:0] GAIN_RESET        = 12'd2011;
  localparam logic [11:0] GAIN_ROUND        = 12'h400;
  localparam int          GAIN_SHIFT        = 11;
  localparam logic [15:0] SPAD_MIDPOINT     = 16'h8000;
  localparam logic [15:0] CLIP16            = 16'hFFFF;

  localparam logic [0:0] REG_TARGET_RATE = 1'd0;
  localparam logic [0:0] REG_GAIN        = 1'd1;

  localparam logic [7:0] RAW_HW1     = 8'd1;
  localparam logic [7:0] RAW_HW2     = 8'd2;
  localparam logic [7:0] RAW_HW3     = 8'd3;
  localparam logic [7:0] RAW_SIGNAL  = 8'd4;
  localparam logic [7:0] RAW_BOUNDS  = 8'd5;
  localparam logic [7:0] RAW_SIGMA   = 8'd6;
  localparam logic [7:0] RAW_WRAP    = 8'd7;
  localparam logic [7:0] RAW_MINCLIP = 8'd8;
  localparam logic [7:0] RAW_DONE    = 8'd9;
  localparam logic [7:0] RAW_XTALK   = 8'd12;
  localparam logic [7:0] RAW_MINRNG  = 8'd13;
  localparam logic [7:0] RAW_HW17    = 8'd17;
  localparam logic [7:0] RAW_SYNC    = 8'd18;

  localparam logic [3:0] ST_VALID    = 4'd0;
  localparam logic [3:0] ST_SIGMA    = 4'd1;
  localparam logic [3:0] ST_SIGNAL   = 4'd2;
  localparam logic [3:0] ST_MINCLIP  = 4'd3;
  localparam logic [3:0] ST_BOUNDS   = 4'd4;
  localparam logic [3:0] ST_HW       = 4'd5;
  localparam logic [3:0] ST_NOWRAP   = 4'd6;
  localparam logic [3:0] ST_WRAP     = 4'd7;
  localparam logic [3:0] ST_XTALK    = 4'd8;
  localparam logic [3:0] ST_SYNC     = 4'd9;
  localparam logic [3:0] ST_MINRANGE = 4'd10;
  localparam logic [3:0] ST_NONE     = 4'd11;

  // {unknown, code}
  function automatic logic [4:0] decode_status(input logic [7:0] st,
                                               input logic [7:0] streams);
    logic [4:0] r;
    r = {1'b0, ST_NONE};
    case (st)
      RAW_HW1, RAW_HW2, RAW_HW3, RAW_HW17: r = {1'b0, ST_HW};
      RAW_MINRNG:  r = {1'b0, ST_MINRANGE};
      RAW_SYNC:    r = {1'b0, ST_SYNC};
      RAW_BOUNDS:  r = {1'b0, ST_BOUNDS};
      RAW_SIGNAL:  r = {1'b0, ST_SIGNAL};
      RAW_SIGMA:   r = {1'b0, ST_SIGMA};
      RAW_WRAP:    r = {1'b0, ST_WRAP};
      RAW_XTALK:   r = {1'b0, ST_XTALK};
      RAW_MINCLIP: r = {1'b0, ST_MINCLIP};
      RAW_DONE:    r = {1'b0, (streams == 8'd0) ? ST_NOWRAP : ST_VALID};
      default:     r = {1'b1, ST_NONE};
    endcase
    return r;
  endfunction

endpackage

// File: rtl/ranging_result_postprocess.sv
// ----------------------------------------------------------------------------
// ranging_result_postprocess
// Gain-corrected range, status decode and dynamic SPAD target per record.
// ----------------------------------------------------------------------------
// Structure: two 32-cell divider rows lie between input transaction and result.
// Throughput: one transaction per cycle; the cell rows advance whenever the
// last cell is empty or its result is taken.
// Reset: target_rate 2560, gain_factor 2011, pipeline emptied.
module ranging_result_postprocess (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  raw_status,
  input  logic [7:0]  stream_cnt,
  input  logic [15:0] effective_spads,
  input  logic [15:0] ambient_rate,
  input  logic [15:0] peak_rate,
  input  logic [15:0] raw_range,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] range_corr,
  output logic [3:0]  status_code,
  output logic        status_unknown,
  output logic [15:0] spad_target,
  output logic        spad_fallback
);

  localparam int W   = rrp_pkg::DIV_W;
  localparam int SW1 = 16 + 4 + 1 + 16 + 1;
  localparam int SW2 = 16 + 4 + 1 + 1;

  logic [15:0] target_rate;
  logic [11:0] gain_factor;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_rate <= rrp_pkg::TARGET_RATE_RESET;
      gain_factor <= rrp_pkg::GAIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        rrp_pkg::REG_TARGET_RATE: target_rate <= cfg_data;
        rrp_pkg::REG_GAIN:        gain_factor <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  logic [28:0]    prod;
  logic [17:0]    scaled;
  logic [15:0]    rng;
  logic [4:0]     st;
  logic [16:0]    sum;
  logic [15:0]    sum_c;
  logic [SW1-1:0] side1_in;

  always_comb begin
    prod     = 29'(raw_range) * 29'(gain_factor) + 29'(rrp_pkg::GAIN_ROUND);
    scaled   = prod[28:rrp_pkg::GAIN_SHIFT];
    rng      = (scaled[17:16] != 2'd0) ? rrp_pkg::CLIP16 : scaled[15:0];
    st       = rrp_pkg::decode_status(raw_status, stream_cnt);
    sum      = {1'b0, peak_rate} + {1'b0, ambient_rate};
    sum_c    = sum[16] ? rrp_pkg::CLIP16 : sum[15:0];
    side1_in = {rng, st, target_rate, effective_spads == 16'd0};
  end

  logic           v1;
  logic [W-1:0]   q1;
  logic [SW1-1:0] side1;

  rrp_div_chain #(.W(W), .SW(SW1)) u_div_rate (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .dividend  ({sum_c, 16'd0}),
    .divisor   ({16'd0, effective_spads}),
    .in_side   (side1_in),
    .out_valid (v1),
    .quotient  (q1),
    .out_side  (side1)
  );

  logic [SW2-1:0] side2_in;
  logic [15:0]    tr1;

  always_comb begin
    tr1      = side1[16:1];
    side2_in = {side1[SW1-1:17], side1[0] || (q1 == '0)};
  end

  logic           v2;
  logic [W-1:0]   q2;
  logic [SW2-1:0] side2;

  rrp_div_chain #(.W(W), .SW(SW2)) u_div_target (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v1),
    .dividend  ({tr1, 16'd0}),
    .divisor   (q1),
    .in_side   (side2_in),
    .out_valid (v2),
    .quotient  (q2),
    .out_side  (side2)
  );

  always_comb begin
    out_valid      = v2;
    range_corr     = side2[21:6];
    status_unknown = side2[5];
    status_code    = side2[4:1];
    spad_fallback  = side2[0];
    if (side2[0]) begin
      spad_target = rrp_pkg::SPAD_MIDPOINT;
    end else if (q2[31:16] != 16'd0) begin
      spad_target = rrp_pkg::CLIP16;
    end else begin
      spad_target = q2[15:0];
    end
  end

endmodule

// File: rtl/rrp_div_cell.sv
// ----------------------------------------------------------------------------
// rrp_div_cell
// One restoring-division step: one quotient bit per cell, side data carried.
// ----------------------------------------------------------------------------
module rrp_div_cell #(
  parameter int W  = 32,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [W-1:0]  in_rem,
  input  logic [W-1:0]  in_dvd,
  input  logic [W-1:0]  in_dsr,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [W-1:0]  out_rem,
  output logic [W-1:0]  out_dvd,
  output logic [W-1:0]  out_dsr,
  output logic [SW-1:0] out_side
);

  logic [W:0]   trial;
  logic         ge;
  logic [W:0]   diff;
  logic [W-1:0] rem_next;
  logic [W-1:0] dvd_next;

  always_comb begin
    trial    = {in_rem, in_dvd[W-1]};
    ge       = trial >= {1'b0, in_dsr};
    diff     = trial - {1'b0, in_dsr};
    rem_next = ge ? diff[W-1:0] : trial[W-1:0];
    dvd_next = {in_dvd[W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rem  <= rem_next;
      out_dvd  <= dvd_next;
      out_dsr  <= in_dsr;
      out_side <= in_side;
    end
  end

endmodule

// File: rtl/rrp_div_chain.sv
// ----------------------------------------------------------------------------
// rrp_div_chain
// Row of W division cells giving a W-bit quotient.
// ----------------------------------------------------------------------------
module rrp_div_chain #(
  parameter int W  = 32,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [W-1:0]  dividend,
  input  logic [W-1:0]  divisor,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [W-1:0]  quotient,
  output logic [SW-1:0] out_side
);

  logic          v_a    [0:W];
  logic [W-1:0]  rem_a  [0:W];
  logic [W-1:0]  dvd_a  [0:W];
  logic [W-1:0]  dsr_a  [0:W];
  logic [SW-1:0] side_a [0:W];

  assign v_a[0]    = in_valid;
  assign rem_a[0]  = '0;
  assign dvd_a[0]  = dividend;
  assign dsr_a[0]  = divisor;
  assign side_a[0] = in_side;

  for (genvar i = 0; i < W; i++) begin : g_cell
    rrp_div_cell #(.W(W), .SW(SW)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (v_a[i]),
      .in_rem    (rem_a[i]),
      .in_dvd    (dvd_a[i]),
      .in_dsr    (dsr_a[i]),
      .in_side   (side_a[i]),
      .out_valid (v_a[i+1]),
      .out_rem   (rem_a[i+1]),
      .out_dvd   (dvd_a[i+1]),
      .out_dsr   (dsr_a[i+1]),
      .out_side  (side_a[i+1])
    );
  end

  assign out_valid = v_a[W];
  assign quotient  = dvd_a[W];
  assign out_side  = side_a[W];

endmodule
